FILE: src/bep_pkg.sv
package bep_pkg;

  // Beat layouts on the two stream sides, packed from bit 0 upward.
  localparam int unsigned InDataWidth  = 104;
  localparam int unsigned OutDataWidth = 40;
  localparam int unsigned CfgIdxWidth  = 3;
  localparam int unsigned CfgDataWidth = 24;

  // Fixed amplitude windows of the two scintillators.
  localparam logic [12:0] AmpSecondMin = 13'd2600;
  localparam logic [12:0] AmpSecondMax = 13'd4300;
  localparam logic [12:0] AmpFirstMin  = 13'd2000;
  localparam logic [12:0] AmpFirstMax  = 13'd4000;

  // Geometry in 1/64 mm: half the wire pitch and the rounded far-plane offsets.
  localparam logic signed [14:0] PitchHalf  = 15'sd40;
  localparam logic signed [14:0] FarXOffset = 15'sd7;
  localparam logic signed [14:0] FarYOffset = 15'sd34;
  localparam logic signed [7:0]  WireCentre = 8'sd33;

  // Round-half-up constant for the Q2.14 product.
  localparam logic signed [32:0] RoundHalf = 33'sd8192;
  localparam int unsigned        RatioFrac = 14;

  localparam logic signed [19:0] Sat16Max = 20'sd32767;
  localparam logic signed [19:0] Sat16Min = -20'sd32768;

  typedef enum logic [1:0] {
    REASON_PASS    = 2'd0,
    REASON_TOF     = 2'd1,
    REASON_CHAMBER = 2'd2,
    REASON_TARGET  = 2'd3
  } reason_e;

  typedef enum logic [CfgIdxWidth-1:0] {
    REG_TOF_DIFF_LOW      = 3'd0,
    REG_TOF_DIFF_HIGH     = 3'd1,
    REG_CHAMBER_DELAY_LOW = 3'd2,
    REG_CHAMBER_DELAY_HI  = 3'd3,
    REG_TARGET_CENTRE_X   = 3'd4,
    REG_TARGET_CENTRE_Y   = 3'd5,
    REG_RADIUS_SQUARED    = 3'd6,
    REG_EXTRAP_RATIO      = 3'd7
  } reg_idx_e;

  // Payload carried from the window checks into the projection stages.
  typedef struct packed {
    reason_e            reason;
    logic signed [14:0] x_near;
    logic signed [14:0] x_diff;
    logic signed [14:0] y_near;
    logic signed [14:0] y_diff;
  } geom_t;

  typedef struct packed {
    reason_e            reason;
    logic signed [14:0] x_near;
    logic signed [14:0] y_near;
    logic signed [31:0] x_prod;
    logic signed [31:0] y_prod;
  } prod_t;

  typedef struct packed {
    reason_e            reason;
    logic signed [15:0] target_x;
    logic signed [15:0] target_y;
  } proj_t;

  typedef struct packed {
    reason_e            reason;
    logic signed [15:0] target_x;
    logic signed [15:0] target_y;
    logic [31:0]        dx_sq;
    logic [31:0]        dy_sq;
  } dist_t;

endpackage

FILE: src/beam_event_prefilter_unit.sv
// Channel  | Direction | Signals                          | Contents
// ---------+-----------+----------------------------------+---------------------------------
// s_axis   | in        | tvalid, tready, tdata[103:0]     | one beam event per beat
// m_axis   | out       | tvalid, tready, tdata[39:0]      | one verdict per event
// cfg      | in        | valid, ready, index[2:0], data   | register writes, always ready
//
// The block is a five-stage pipeline: window checks and wire positions, the two
// Q2.14 multiplies, rounding with saturation, the two squares, and the radius
// compare. A new event is taken in every cycle while the output is not stalled.
// A stalled output freezes every stage together, so nothing is lost or repeated,
// while the output register still lets a new event enter once its beat is taken.
// Reset (rst_ni low, asynchronous) empties the pipeline and loads the register
// defaults; there is no clearing pass.
module beam_event_prefilter_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // tdata, lowest bit up: amp_second[12:0], time_second[28:13], amp_first[41:29],
  // time_first[57:42], chamber_time[73:58], wire_x_near[79:74], wire_x_far[85:80],
  // wire_y_near[91:86], wire_y_far[97:92], zero fill[103:98].
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  input  logic [bep_pkg::InDataWidth-1:0]     s_axis_tdata_i,
  // tdata, lowest bit up: accepted[0], reject_reason[2:1], target_x[18:3],
  // target_y[34:19], zero fill[39:35].
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  output logic [bep_pkg::OutDataWidth-1:0]    m_axis_tdata_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [bep_pkg::CfgIdxWidth-1:0]     cfg_index_i,
  input  logic [bep_pkg::CfgDataWidth-1:0]    cfg_data_i
);
  import bep_pkg::*;

  // Configuration registers.
  logic signed [15:0] tof_lo_q, tof_hi_q, dly_lo_q, dly_hi_q;
  logic signed [15:0] centre_x_q, centre_y_q;
  logic [23:0]        radius_sq_q;
  logic [15:0]        ratio_q;

  // Pipeline valid bits and payload registers.
  logic v1_q, v2_q, v3_q, v4_q, v5_q;
  geom_t s1_d, s1_q;
  prod_t s2_d, s2_q;
  proj_t s3_d, s3_q;
  dist_t s4_d, s4_q;
  logic  acc5_d, acc5_q;
  reason_e reason5_d, reason5_q;
  logic signed [15:0] tx5_q, ty5_q;

  // The whole pipeline advances together whenever the output beat is free or taken.
  logic pipe_en;
  assign pipe_en         = !v5_q || m_axis_tready_i;
  assign s_axis_tready_o = pipe_en;
  assign cfg_ready_o     = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tof_lo_q    <= 16'sd103;
      tof_hi_q    <= 16'sd115;
      dly_lo_q    <= 16'sd65;
      dly_hi_q    <= 16'sd95;
      centre_x_q  <= -16'sd64;
      centre_y_q  <= 16'sd141;
      radius_sq_q <= 24'd262144;
      ratio_q     <= 16'd24501;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_TOF_DIFF_LOW:      tof_lo_q    <= cfg_data_i[15:0];
        REG_TOF_DIFF_HIGH:     tof_hi_q    <= cfg_data_i[15:0];
        REG_CHAMBER_DELAY_LOW: dly_lo_q    <= cfg_data_i[15:0];
        REG_CHAMBER_DELAY_HI:  dly_hi_q    <= cfg_data_i[15:0];
        REG_TARGET_CENTRE_X:   centre_x_q  <= cfg_data_i[15:0];
        REG_TARGET_CENTRE_Y:   centre_y_q  <= cfg_data_i[15:0];
        REG_RADIUS_SQUARED:    radius_sq_q <= cfg_data_i;
        REG_EXTRAP_RATIO:      ratio_q     <= cfg_data_i[15:0];
        default:               ;
      endcase
    end
  end

  // Stage 1: unpack, window checks and wire positions.
  logic [12:0] amp2, amp1;
  logic [15:0] t2, t1, tc;
  logic [5:0]  w_xn, w_xf, w_yn, w_yf;
  logic signed [16:0] tof_diff, delay;
  logic signed [7:0]  u_xn, u_xf, u_yn, u_yf;
  logic signed [14:0] p_xn, p_xf, p_yn, p_yf;
  logic tof_bad, dly_bad;

  always_comb begin
    amp2 = s_axis_tdata_i[12:0];
    t2   = s_axis_tdata_i[28:13];
    amp1 = s_axis_tdata_i[41:29];
    t1   = s_axis_tdata_i[57:42];
    tc   = s_axis_tdata_i[73:58];
    w_xn = s_axis_tdata_i[79:74];
    w_xf = s_axis_tdata_i[85:80];
    w_yn = s_axis_tdata_i[91:86];
    w_yf = s_axis_tdata_i[97:92];

    tof_diff = $signed({1'b0, t2}) - $signed({1'b0, t1});
    delay    = $signed({1'b0, tc}) - $signed({1'b0, t2});

    tof_bad = (amp2 < AmpSecondMin) || (amp2 > AmpSecondMax) ||
              (amp1 < AmpFirstMin) || (amp1 > AmpFirstMax) ||
              (tof_diff < $signed({tof_lo_q[15], tof_lo_q})) ||
              (tof_diff > $signed({tof_hi_q[15], tof_hi_q}));
    dly_bad = (delay < $signed({dly_lo_q[15], dly_lo_q})) ||
              (delay > $signed({dly_hi_q[15], dly_hi_q}));

    // Wire number to signed half-pitch count: 2*wire - 33.
    u_xn = $signed({1'b0, w_xn, 1'b0}) - WireCentre;
    u_xf = $signed({1'b0, w_xf, 1'b0}) - WireCentre;
    u_yn = $signed({1'b0, w_yn, 1'b0}) - WireCentre;
    u_yf = $signed({1'b0, w_yf, 1'b0}) - WireCentre;

    // The x planes count wires in the opposite sense to the y planes.
    p_xn = -(PitchHalf * $signed({{7{u_xn[7]}}, u_xn}));
    p_xf = FarXOffset - (PitchHalf * $signed({{7{u_xf[7]}}, u_xf}));
    p_yn = PitchHalf * $signed({{7{u_yn[7]}}, u_yn});
    p_yf = FarYOffset + (PitchHalf * $signed({{7{u_yf[7]}}, u_yf}));

    if (tof_bad) begin
      s1_d.reason = REASON_TOF;
    end else if (dly_bad) begin
      s1_d.reason = REASON_CHAMBER;
    end else begin
      s1_d.reason = REASON_PASS;
    end
    s1_d.x_near = p_xn;
    s1_d.x_diff = p_xf - p_xn;
    s1_d.y_near = p_yn;
    s1_d.y_diff = p_yf - p_yn;
  end

  // Stage 2: plane difference times the Q2.14 ratio.
  logic signed [16:0] ratio_s;
  always_comb begin
    ratio_s     = $signed({1'b0, ratio_q});
    s2_d.reason = s1_q.reason;
    s2_d.x_near = s1_q.x_near;
    s2_d.y_near = s1_q.y_near;
    s2_d.x_prod = 32'(s1_q.x_diff * ratio_s);
    s2_d.y_prod = 32'(s1_q.y_diff * ratio_s);
  end

  // Stage 3: round half up, add the near position, saturate to 16 bits.
  logic signed [32:0] x_rnd, y_rnd;
  logic signed [19:0] x_sum, y_sum;
  logic signed [15:0] x_sat, y_sat;
  always_comb begin
    x_rnd = $signed({s2_q.x_prod[31], s2_q.x_prod}) + RoundHalf;
    y_rnd = $signed({s2_q.y_prod[31], s2_q.y_prod}) + RoundHalf;
    x_sum = $signed({x_rnd[32], x_rnd[32:RatioFrac]}) +
            $signed({{5{s2_q.x_near[14]}}, s2_q.x_near});
    y_sum = $signed({y_rnd[32], y_rnd[32:RatioFrac]}) +
            $signed({{5{s2_q.y_near[14]}}, s2_q.y_near});

    if (x_sum > Sat16Max) begin
      x_sat = 16'sh7fff;
    end else if (x_sum < Sat16Min) begin
      x_sat = -16'sh8000;
    end else begin
      x_sat = x_sum[15:0];
    end
    if (y_sum > Sat16Max) begin
      y_sat = 16'sh7fff;
    end else if (y_sum < Sat16Min) begin
      y_sat = -16'sh8000;
    end else begin
      y_sat = y_sum[15:0];
    end

    // Events rejected by the window checks report a zero position.
    s3_d.reason   = s2_q.reason;
    s3_d.target_x = (s2_q.reason == REASON_PASS) ? x_sat : 16'sd0;
    s3_d.target_y = (s2_q.reason == REASON_PASS) ? y_sat : 16'sd0;
  end

  // Stage 4: offsets from the target centre, squared.
  logic signed [16:0] dx, dy;
  logic signed [33:0] dx_prod, dy_prod;
  always_comb begin
    dx      = $signed({s3_q.target_x[15], s3_q.target_x}) -
              $signed({centre_x_q[15], centre_x_q});
    dy      = $signed({s3_q.target_y[15], s3_q.target_y}) -
              $signed({centre_y_q[15], centre_y_q});
    dx_prod = dx * dx;
    dy_prod = dy * dy;
    s4_d.reason   = s3_q.reason;
    s4_d.target_x = s3_q.target_x;
    s4_d.target_y = s3_q.target_y;
    s4_d.dx_sq    = dx_prod[31:0];
    s4_d.dy_sq    = dy_prod[31:0];
  end

  // Stage 5: radius compare and final verdict.
  logic [32:0] dist_sq;
  always_comb begin
    dist_sq = {1'b0, s4_q.dx_sq} + {1'b0, s4_q.dy_sq};
    if (s4_q.reason != REASON_PASS) begin
      reason5_d = s4_q.reason;
    end else if (dist_sq <= {9'd0, radius_sq_q}) begin
      reason5_d = REASON_PASS;
    end else begin
      reason5_d = REASON_TARGET;
    end
    acc5_d = (reason5_d == REASON_PASS);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else if (pipe_en) begin
      v1_q <= s_axis_tvalid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      s1_q      <= s1_d;
      s2_q      <= s2_d;
      s3_q      <= s3_d;
      s4_q      <= s4_d;
      acc5_q    <= acc5_d;
      reason5_q <= reason5_d;
      tx5_q     <= s4_q.target_x;
      ty5_q     <= s4_q.target_y;
    end
  end

  assign m_axis_tvalid_o = v5_q;
  assign m_axis_tdata_o  = {5'd0, ty5_q, tx5_q, reason5_q, acc5_q};

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import bep_pkg::*;

  // Cycles without any accepted beat before the run is declared hung. The slowest
  // legal stretch is a long sender gap or receiver stall plus the five-stage pipeline,
  // so this leaves a wide margin.
  localparam int unsigned StallLimit = 2000;

  // One beam event as it sits in s_axis_tdata[97:0]. The last member is bit 0.
  typedef struct packed {
    logic [5:0]  wire_y_far;
    logic [5:0]  wire_y_near;
    logic [5:0]  wire_x_far;
    logic [5:0]  wire_x_near;
    logic [15:0] chamber_time;
    logic [15:0] time_first;
    logic [12:0] amp_first;
    logic [15:0] time_second;
    logic [12:0] amp_second;
  } beam_event_t;

  // One verdict as it sits in m_axis_tdata[34:0]. The last member is bit 0.
  typedef struct packed {
    logic signed [15:0] target_y;
    logic signed [15:0] target_x;
    reason_e            reason;
    logic               accepted;
  } verdict_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  always #5 clk_i = ~clk_i;

  // Event stream toward the block.
  logic              s_valid = 1'b0;
  logic              s_ready;
  beam_event_t       s_event = '0;
  // Verdict stream out of the block.
  logic              m_valid;
  logic              m_ready = 1'b0;
  logic [39:0]       m_data;
  // Register write channel.
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [CfgIdxWidth-1:0]  cfg_index = '0;
  logic [CfgDataWidth-1:0] cfg_data = '0;

  beam_event_prefilter_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    // tdata, lowest bit up: amp_second, time_second, amp_first, time_first,
    // chamber_time, wire_x_near, wire_x_far, wire_y_near, wire_y_far, zero fill.
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  ({6'b0, s_event}),
    // tdata, lowest bit up: accepted, reject_reason, target_x, target_y, zero fill.
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data)
  );

  // Our own copy of the register file, updated on every accepted write beat.
  logic signed [15:0] tof_lo = 16'sd103;
  logic signed [15:0] tof_hi = 16'sd115;
  logic signed [15:0] dly_lo = 16'sd65;
  logic signed [15:0] dly_hi = 16'sd95;
  logic signed [15:0] centre_x = -16'sd64;
  logic signed [15:0] centre_y = 16'sd141;
  logic [23:0]        radius_sq = 24'd262144;
  logic [15:0]        ratio = 16'd24501;

  beam_event_t pending_events[$];
  verdict_t    expected_verdicts[$];

  int  errors = 0;
  int  verdicts_seen = 0;
  int  idle_cycles = 0;
  int  gap_left = 0;
  int  stall_left = 0;
  // When set, neither side inserts gaps, so back-to-back beats are covered too.
  bit  calm = 1'b0;
  verdict_t mon_got;
  verdict_t mon_want;

  task automatic report_mismatch(string what);
    $display("mismatch: %s", what);
    errors++;
  endtask

  // ---------------------------------------------------------------------------
  // Verdict prediction.
  // ---------------------------------------------------------------------------

  // Wire number to plane position in 1/64 mm. The x planes count the other way.
  function automatic int wire_pos(logic [5:0] wire_no, bit is_y, int offset);
    int u;
    u = 2 * int'(wire_no) - int'(WireCentre);
    return (is_y ? int'(PitchHalf) * u : -int'(PitchHalf) * u) + offset;
  endfunction

  // Extrapolates from the near plane through the far plane to the target with the
  // Q2.14 ratio, rounding half up and saturating to 16 bits.
  function automatic logic signed [15:0] project_to_target(int near_pos, int far_pos);
    longint p;
    p = longint'(near_pos) +
        ((longint'(far_pos - near_pos) * longint'(ratio) + longint'(RoundHalf))
         >>> RatioFrac);
    if (p > longint'(Sat16Max)) return 16'sh7fff;
    if (p < longint'(Sat16Min)) return -16'sh8000;
    return 16'(p);
  endfunction

  function automatic verdict_t predict_verdict(beam_event_t ev);
    int       tof_diff;
    int       delay;
    longint   dx;
    longint   dy;
    verdict_t v;
    v = '0;
    tof_diff = int'(ev.time_second) - int'(ev.time_first);
    delay = int'(ev.chamber_time) - int'(ev.time_second);
    if (ev.amp_second < AmpSecondMin || ev.amp_second > AmpSecondMax ||
        ev.amp_first < AmpFirstMin || ev.amp_first > AmpFirstMax ||
        tof_diff < int'(tof_lo) || tof_diff > int'(tof_hi)) begin
      v.reason = REASON_TOF;
    end else if (delay < int'(dly_lo) || delay > int'(dly_hi)) begin
      v.reason = REASON_CHAMBER;
    end else begin
      v.target_x = project_to_target(wire_pos(ev.wire_x_near, 1'b0, 0),
                                     wire_pos(ev.wire_x_far, 1'b0, int'(FarXOffset)));
      v.target_y = project_to_target(wire_pos(ev.wire_y_near, 1'b1, 0),
                                     wire_pos(ev.wire_y_far, 1'b1, int'(FarYOffset)));
      dx = longint'(v.target_x) - longint'(centre_x);
      dy = longint'(v.target_y) - longint'(centre_y);
      v.reason = (dx * dx + dy * dy <= longint'(radius_sq)) ? REASON_PASS : REASON_TARGET;
    end
    v.accepted = (v.reason == REASON_PASS);
    return v;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------------

  // Mostly short gaps, now and then a long one.
  function automatic int draw_gap();
    int r;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(12, 4);
    return $urandom_range(80, 30);
  endfunction

  // A value in [lo, hi] that lands on either bound fairly often.
  function automatic int pick_biased(int lo, int hi);
    int r;
    r = $urandom_range(99);
    if (r < 15) return lo;
    if (r < 30) return hi;
    return lo + int'($urandom_range(hi - lo));
  endfunction

  // Most events are built to pass the windows under the current registers so that
  // the projection and the radius test see real traffic; the rest are pure noise
  // or miss one window by a little or by a lot.
  function automatic beam_event_t random_event();
    beam_event_t  ev;
    logic [127:0] raw;
    int           r;
    int           tof_v;
    int           t1;
    int           t2;
    int           lo;
    int           hi;
    raw = {$urandom, $urandom, $urandom, $urandom};
    ev = raw[97:0];
    r = $urandom_range(99);
    if (r < 8) return ev;

    if ($urandom_range(1) == 1) begin
      // Wires near the beam axis give projections around the target.
      ev.wire_x_near = 6'($urandom_range(21, 12));
      ev.wire_x_far  = 6'($urandom_range(21, 12));
      ev.wire_y_near = 6'($urandom_range(21, 12));
      ev.wire_y_far  = 6'($urandom_range(21, 12));
    end
    if ($urandom_range(9) == 0) ev.wire_x_far = ev.wire_x_near;

    ev.amp_second = 13'(pick_biased(int'(AmpSecondMin), int'(AmpSecondMax)));
    ev.amp_first  = 13'(pick_biased(int'(AmpFirstMin), int'(AmpFirstMax)));
    if (tof_lo <= tof_hi) begin
      tof_v = pick_biased(int'(tof_lo), int'(tof_hi));
      t1 = (tof_v >= 0) ? pick_biased(0, 65535 - tof_v) : pick_biased(-tof_v, 65535);
      ev.time_first  = 16'(t1);
      ev.time_second = 16'(t1 + tof_v);
    end
    t2 = int'(ev.time_second);
    if (dly_lo <= dly_hi) begin
      lo = (int'(dly_lo) > -t2) ? int'(dly_lo) : -t2;
      hi = (int'(dly_hi) < 65535 - t2) ? int'(dly_hi) : 65535 - t2;
      if (lo <= hi) ev.chamber_time = 16'(t2 + pick_biased(lo, hi));
    end

    if (r < 16) begin
      if (r < 12) begin
        ev.amp_second = r[0] ? 13'(pick_biased(0, int'(AmpSecondMin) - 1))
                             : 13'(pick_biased(int'(AmpSecondMax) + 1, 8191));
      end else begin
        ev.amp_first = r[0] ? 13'(pick_biased(0, int'(AmpFirstMin) - 1))
                            : 13'(pick_biased(int'(AmpFirstMax) + 1, 8191));
      end
    end else if (r < 24) begin
      // Time-of-flight difference one count outside the window, or anywhere.
      t1 = r[0] ? t2 - (int'(tof_hi) + 1) : t2 - (int'(tof_lo) - 1);
      if (r < 20 || t1 < 0 || t1 > 65535) ev.time_first = 16'($urandom);
      else ev.time_first = 16'(t1);
    end else if (r < 32) begin
      lo = r[0] ? t2 + int'(dly_hi) + 1 : t2 + int'(dly_lo) - 1;
      if (r < 28 || lo < 0 || lo > 65535) ev.chamber_time = 16'($urandom);
      else ev.chamber_time = 16'(lo);
    end
    return ev;
  endfunction

  // A clean event for the reset windows: amplitudes mid-range, difference 110,
  // chamber delay 80, all four wires on wire 16.
  function automatic beam_event_t base_event();
    beam_event_t ev;
    ev.amp_second   = 13'd3000;
    ev.amp_first    = 13'd3000;
    ev.time_first   = 16'd1000;
    ev.time_second  = 16'd1110;
    ev.chamber_time = 16'd1190;
    ev.wire_x_near  = 6'd16;
    ev.wire_x_far   = 6'd16;
    ev.wire_y_near  = 6'd16;
    ev.wire_y_far   = 6'd16;
    return ev;
  endfunction

  // Window edges under the reset registers, field extremes and equal x wires.
  task automatic queue_window_cases();
    beam_event_t ev;
    ev = base_event();                          pending_events.push_back(ev);
    ev = base_event(); ev.amp_second = 13'd2599; pending_events.push_back(ev);
    ev = base_event(); ev.amp_second = 13'd2600; pending_events.push_back(ev);
    ev = base_event(); ev.amp_second = 13'd4300; pending_events.push_back(ev);
    ev = base_event(); ev.amp_second = 13'd4301; pending_events.push_back(ev);
    ev = base_event(); ev.amp_first = 13'd1999;  pending_events.push_back(ev);
    ev = base_event(); ev.amp_first = 13'd2000;  pending_events.push_back(ev);
    ev = base_event(); ev.amp_first = 13'd4000;  pending_events.push_back(ev);
    ev = base_event(); ev.amp_first = 13'd4001;  pending_events.push_back(ev);
    ev = base_event(); ev.amp_second = 13'h1fff; ev.amp_first = '0;
    pending_events.push_back(ev);
    ev = base_event(); ev.time_first = 16'd1008; pending_events.push_back(ev);
    ev = base_event(); ev.time_first = 16'd1007; pending_events.push_back(ev);
    ev = base_event(); ev.time_first = 16'd995;  pending_events.push_back(ev);
    ev = base_event(); ev.time_first = 16'd994;  pending_events.push_back(ev);
    ev = base_event(); ev.chamber_time = 16'd1174; pending_events.push_back(ev);
    ev = base_event(); ev.chamber_time = 16'd1175; pending_events.push_back(ev);
    ev = base_event(); ev.chamber_time = 16'd1205; pending_events.push_back(ev);
    ev = base_event(); ev.chamber_time = 16'd1206; pending_events.push_back(ev);
    ev = base_event(); {ev.wire_x_near, ev.wire_x_far, ev.wire_y_near, ev.wire_y_far} = '0;
    pending_events.push_back(ev);
    ev = base_event(); {ev.wire_x_near, ev.wire_x_far, ev.wire_y_near, ev.wire_y_far} = '1;
    pending_events.push_back(ev);
    ev = base_event(); ev.wire_x_near = 6'd0; ev.wire_x_far = 6'd63;
    ev.wire_y_near = 6'd63; ev.wire_y_far = 6'd0;
    pending_events.push_back(ev);
    ev = base_event(); ev.wire_x_near = 6'd5; ev.wire_x_far = 6'd5;
    ev.wire_y_near = 6'd40; ev.wire_y_far = 6'd40;
    pending_events.push_back(ev);
    // Times at the top of the range: passes time of flight, fails the chamber.
    ev = base_event(); ev.time_first = 16'd65425; ev.time_second = 16'hffff;
    ev.chamber_time = 16'hffff;
    pending_events.push_back(ev);
    ev = base_event(); ev.time_first = '0; ev.time_second = '0; ev.chamber_time = '0;
    pending_events.push_back(ev);
  endtask

  // With a zero ratio the target point is the near-plane point; wire 16 sits at
  // x = +40 and y = -40, wire 17 one pitch away.
  task automatic queue_geometry_cases();
    beam_event_t ev;
    ev = base_event();                        pending_events.push_back(ev);
    ev = base_event(); ev.wire_x_near = 6'd17; pending_events.push_back(ev);
    ev = base_event(); ev.wire_y_near = 6'd17; pending_events.push_back(ev);
    ev = base_event(); ev.wire_x_far = 6'd63; ev.wire_y_far = 6'd0;
    pending_events.push_back(ev);
  endtask

  // ---------------------------------------------------------------------------
  // Register writes and phase control, run from the initial block below.
  // ---------------------------------------------------------------------------

  task automatic write_reg(reg_idx_e idx, logic [23:0] value);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_TOF_DIFF_LOW:      tof_lo = value[15:0];
      REG_TOF_DIFF_HIGH:     tof_hi = value[15:0];
      REG_CHAMBER_DELAY_LOW: dly_lo = value[15:0];
      REG_CHAMBER_DELAY_HI:  dly_hi = value[15:0];
      REG_TARGET_CENTRE_X:   centre_x = value[15:0];
      REG_TARGET_CENTRE_Y:   centre_y = value[15:0];
      REG_RADIUS_SQUARED:    radius_sq = value;
      REG_EXTRAP_RATIO:      ratio = value[15:0];
      default: ;
    endcase
  endtask

  task automatic write_all(int t_lo, int t_hi, int d_lo, int d_hi, int cx, int cy,
                           int rsq, int rat);
    write_reg(REG_TOF_DIFF_LOW, 24'(t_lo));
    write_reg(REG_TOF_DIFF_HIGH, 24'(t_hi));
    write_reg(REG_CHAMBER_DELAY_LOW, 24'(d_lo));
    write_reg(REG_CHAMBER_DELAY_HI, 24'(d_hi));
    write_reg(REG_TARGET_CENTRE_X, 24'(cx));
    write_reg(REG_TARGET_CENTRE_Y, 24'(cy));
    write_reg(REG_RADIUS_SQUARED, 24'(rsq));
    write_reg(REG_EXTRAP_RATIO, 24'(rat));
  endtask

  // Every beat causes exactly one verdict, so the block is idle once the queue of
  // pending events is empty, the last beat is gone and every verdict has arrived.
  // The check runs on the falling edge, after the driver and monitor have settled.
  task automatic wait_idle();
    do @(negedge clk_i);
    while (pending_events.size() != 0 || s_valid || expected_verdicts.size() != 0);
  endtask

  task automatic run_random(int count, bit quiet_mode);
    @(negedge clk_i);
    calm = quiet_mode;
    repeat (count) pending_events.push_back(random_event());
    wait_idle();
  endtask

  initial begin
    int lo;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset registers: window edges first, then traffic.
    @(negedge clk_i);
    queue_window_cases();
    run_random(200, 1'b0);

    // Full-range windows, zero ratio, zero radius: only an exact hit passes.
    write_all(-32768, 32767, -32768, 32767, 40, -40, 0, 0);
    @(negedge clk_i);
    queue_geometry_cases();
    run_random(60, 1'b1);

    // Largest ratio and radius with the centre in the far corner.
    write_all(-32768, 32767, 65, 95, 32767, -32768, 16777215, 65535);
    run_random(100, 1'b0);

    // An inverted time-of-flight window rejects everything, then the same for the
    // chamber window.
    write_reg(REG_TOF_DIFF_LOW, 24'(10));
    write_reg(REG_TOF_DIFF_HIGH, 24'(-10));
    run_random(30, 1'b0);
    write_all(103, 115, 95, 65, -64, 141, 262144, 24501);
    run_random(30, 1'b0);

    // Random but sensible settings.
    repeat (4) begin
      lo = $urandom_range(400) - 200;
      write_all(lo, lo + int'($urandom_range(300)), lo, lo + int'($urandom_range(300)),
                int'($urandom_range(3000)) - 1500, int'($urandom_range(3000)) - 1500,
                int'($urandom_range(1 << 21)), int'($urandom_range(65535)));
      run_random(110, $urandom_range(3) == 0);
    end

    // Let the pipeline run dry before the verdict.
    repeat (10) @(posedge clk_i);
    if (expected_verdicts.size() != 0) begin
      report_mismatch($sformatf("%0d events never got a verdict", expected_verdicts.size()));
    end
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Driver: presents the next pending event, holds it until its beat is taken,
  // and records the expected verdict at that very edge.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_valid  <= 1'b0;
      gap_left <= 0;
    end else begin
      if (s_valid && s_ready) begin
        expected_verdicts.push_back(predict_verdict(s_event));
      end
      if (!s_valid || s_ready) begin
        if (gap_left > 0) begin
          s_valid  <= 1'b0;
          gap_left <= gap_left - 1;
        end else if (pending_events.size() != 0) begin
          s_event  <= pending_events.pop_front();
          s_valid  <= 1'b1;
          gap_left <= calm ? 0 : draw_gap();
        end else begin
          s_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: checks each verdict beat against the oldest expectation, throttles
  // tready, and counts cycles in which no channel moved a beat.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_ready     <= 1'b0;
      stall_left  <= 0;
      idle_cycles <= 0;
    end else begin
      if (m_valid && m_ready) begin
        mon_got = m_data[34:0];
        if (expected_verdicts.size() == 0) begin
          report_mismatch($sformatf("verdict %0d arrived with no event pending",
                                    verdicts_seen));
        end else begin
          mon_want = expected_verdicts.pop_front();
          if (mon_got.accepted !== mon_want.accepted)
            report_mismatch($sformatf("verdict %0d: accepted %0d, expected %0d",
                                      verdicts_seen, mon_got.accepted, mon_want.accepted));
          if (mon_got.reason !== mon_want.reason)
            report_mismatch($sformatf("verdict %0d: reason %0d, expected %0d",
                                      verdicts_seen, mon_got.reason, mon_want.reason));
          if (mon_got.target_x !== mon_want.target_x)
            report_mismatch($sformatf("verdict %0d: target_x %0d, expected %0d",
                                      verdicts_seen, mon_got.target_x, mon_want.target_x));
          if (mon_got.target_y !== mon_want.target_y)
            report_mismatch($sformatf("verdict %0d: target_y %0d, expected %0d",
                                      verdicts_seen, mon_got.target_y, mon_want.target_y));
        end
        verdicts_seen++;
      end

      if (stall_left > 0) begin
        m_ready    <= 1'b0;
        stall_left <= stall_left - 1;
      end else begin
        m_ready    <= 1'b1;
        stall_left <= calm ? 0 : draw_gap();
      end

      if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // A hung handshake ends the run here.
  initial begin
    wait (idle_cycles >= StallLimit);
    $display("simulation failed");
    $finish;
  end

endmodule
